@@ rtl/core/sipcdc_pkg.sv @@
// Shared types, codes and constants of the SIP call dialog controller.
// Used by every module of the block; it depends on nothing else.
package sipcdc_pkg;

    // Default width of the stored call-id keys and the width of the call-id field.
    localparam int ID_BITS_DEF = 32;
    localparam int CALL_ID_W   = 32;

    // Depth of the result queue in front of the output channel.
    localparam int RES_DEPTH = 4;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_FIRST_RETRY   = 3'd0;
    localparam logic [2:0] REG_RETRY_CEILING = 3'd1;
    localparam logic [2:0] REG_ACK_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_REFRESH       = 3'd3;
    localparam logic [2:0] REG_REG_RETRY     = 3'd4;

    // Register reset values.
    localparam logic [15:0] FIRST_RETRY_RST   = 16'd500;
    localparam logic [15:0] RETRY_CEILING_RST = 16'd4000;
    localparam logic [19:0] ACK_TIMEOUT_RST   = 20'd32000;
    localparam logic [31:0] REFRESH_RST       = 32'd1800000;
    localparam logic [31:0] REG_RETRY_RST     = 32'd60000;

    // SIP status codes that the block looks at.
    localparam logic [9:0] STATUS_NONE     = 10'd0;
    localparam logic [9:0] STATUS_OK       = 10'd200;
    localparam logic [9:0] STATUS_FAIL_MIN = 10'd400;

    // Classified input events.
    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_PLACE      = 4'd1,
        CMD_CALL_RESP  = 4'd2,
        CMD_NO_ANSWER  = 4'd3,
        CMD_INVITE     = 4'd4,
        CMD_BYE        = 4'd5,
        CMD_CANCEL     = 4'd6,
        CMD_ACK        = 4'd7,
        CMD_OPTIONS    = 4'd8,
        CMD_ANSWER     = 4'd9,
        CMD_REJECT     = 4'd10,
        CMD_HANGUP     = 4'd11,
        CMD_REG_RESULT = 4'd12
    } cmd_t;

    // Messages the surrounding logic is told to send.
    typedef enum logic [3:0] {
        MSG_NONE       = 4'd0,
        MSG_REGISTER   = 4'd1,
        MSG_INVITE     = 4'd2,
        MSG_ACK        = 4'd3,
        MSG_BYE        = 4'd4,
        MSG_CANCEL     = 4'd5,
        MSG_RINGING    = 4'd6,
        MSG_OK_SDP     = 4'd7,
        MSG_OK_RESEND  = 4'd8,
        MSG_BUSY       = 4'd9,
        MSG_BUSY_GEN   = 4'd10,
        MSG_TERMINATED = 4'd11,
        MSG_OK_GEN     = 4'd12
    } msg_t;

    // Call state, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_CALLING = 4'b0010,
        ST_RINGING = 4'b0100,
        ST_INCALL  = 4'b1000
    } state_t;

    // Configuration register values.
    typedef struct packed {
        logic [15:0] first_retry_ms;
        logic [15:0] retry_ceiling_ms;
        logic [19:0] ack_timeout_ms;
        logic [31:0] refresh_ms;
        logic [31:0] reg_retry_ms;
    } cfg_t;

    // One result item.
    typedef struct packed {
        msg_t       message;
        logic [1:0] call_state;
        logic       media_on;
        logic       ended_by_peer;
        logic       request_ok;
        logic       last;
    } result_t;

    // Results of one accepted item, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    // Binary code of the call state as it appears on the output.
    function automatic logic [1:0] state_code(state_t s);
        logic [1:0] code;
        case (s)
            ST_IDLE:    code = 2'd0;
            ST_CALLING: code = 2'd1;
            ST_RINGING: code = 2'd2;
            ST_INCALL:  code = 2'd3;
            default:    code = 2'd0;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/core/sipcdc_cfg_regs.sv @@
// Configuration registers of the SIP call dialog controller behind an APB-style port.
// Depends on sipcdc_pkg for the register indexes, reset values and cfg_t.
module sipcdc_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output sipcdc_pkg::cfg_t   cfg
);
    import sipcdc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] index;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    // Register writes in the access phase of a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.first_retry_ms   <= FIRST_RETRY_RST;
            cfg_reg.retry_ceiling_ms <= RETRY_CEILING_RST;
            cfg_reg.ack_timeout_ms   <= ACK_TIMEOUT_RST;
            cfg_reg.refresh_ms       <= REFRESH_RST;
            cfg_reg.reg_retry_ms     <= REG_RETRY_RST;
        end else if (wr_en) begin
            case (index)
                REG_FIRST_RETRY:   cfg_reg.first_retry_ms   <= pwdata[15:0];
                REG_RETRY_CEILING: cfg_reg.retry_ceiling_ms <= pwdata[15:0];
                REG_ACK_TIMEOUT:   cfg_reg.ack_timeout_ms   <= pwdata[19:0];
                REG_REFRESH:       cfg_reg.refresh_ms       <= pwdata;
                REG_REG_RETRY:     cfg_reg.reg_retry_ms     <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back multiplexer; unused addresses read as zero.
    always_comb begin
        case (index)
            REG_FIRST_RETRY:   prdata = {16'd0, cfg_reg.first_retry_ms};
            REG_RETRY_CEILING: prdata = {16'd0, cfg_reg.retry_ceiling_ms};
            REG_ACK_TIMEOUT:   prdata = {12'd0, cfg_reg.ack_timeout_ms};
            REG_REFRESH:       prdata = cfg_reg.refresh_ms;
            REG_REG_RETRY:     prdata = cfg_reg.reg_retry_ms;
            default:           prdata = 32'd0;
        endcase
    end

endmodule

@@ rtl/core/sipcdc_core.sv @@
// Call state registers and the single-pass event logic of the SIP call dialog controller.
// Depends on sipcdc_pkg; its results go to the result queue in the same cycle.
module sipcdc_core #(
    parameter int ID_BITS = sipcdc_pkg::ID_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_fire,
    input  logic [3:0]                        command,
    input  logic [sipcdc_pkg::CALL_ID_W-1:0]  call_id,
    input  logic [9:0]                        status_code,
    input  logic                              media_valid,
    input  sipcdc_pkg::cfg_t                  cfg,
    output sipcdc_pkg::push_t                 push
);
    import sipcdc_pkg::*;

    // State registers.
    state_t             state_reg,       state_next;
    logic [ID_BITS-1:0] active_id_reg,   active_id_next;
    logic [ID_BITS-1:0] incoming_id_reg, incoming_id_next;
    logic               await_ack_reg,   await_ack_next;
    logic [15:0]        retry_int_reg,   retry_int_next;
    logic [15:0]        retry_cd_reg,    retry_cd_next;
    logic [19:0]        giveup_cd_reg,   giveup_cd_next;
    logic               media_reg,       media_next;
    logic               reg_armed_reg,   reg_armed_next;
    logic               reg_pending_reg, reg_pending_next;
    logic [31:0]        reg_cd_reg,      reg_cd_next;

    logic [ID_BITS-1:0] cid;
    logic [16:0]        retry_double;
    logic [31:0]        reg_cd_dec;
    msg_t               msg0, msg1;
    logic [1:0]         count;
    logic               ended;
    logic               ok;

    // Call-id key cut or widened to the stored width.
    if (ID_BITS > CALL_ID_W) begin : g_id_wide
        assign cid = {{(ID_BITS - CALL_ID_W){1'b0}}, call_id};
    end else begin : g_id_narrow
        assign cid = call_id[ID_BITS-1:0];
    end

    assign retry_double = {retry_int_reg, 1'b0};
    assign reg_cd_dec   = (reg_cd_reg != 32'd0) ? reg_cd_reg - 32'd1 : 32'd0;

    // Next state and the messages caused by one event.
    always_comb begin
        state_next       = state_reg;
        active_id_next   = active_id_reg;
        incoming_id_next = incoming_id_reg;
        await_ack_next   = await_ack_reg;
        retry_int_next   = retry_int_reg;
        retry_cd_next    = retry_cd_reg;
        giveup_cd_next   = giveup_cd_reg;
        media_next       = media_reg;
        reg_armed_next   = reg_armed_reg;
        reg_pending_next = reg_pending_reg;
        reg_cd_next      = reg_cd_reg;
        msg0             = MSG_NONE;
        msg1             = MSG_NONE;
        count            = 2'd0;
        ended            = 1'b0;
        ok               = 1'b0;

        case (cmd_t'(command))
            CMD_TICK: begin
                // 200 OK retransmission and the ACK give-up timer.
                if (await_ack_reg) begin
                    if (giveup_cd_reg <= 20'd1) begin
                        giveup_cd_next = 20'd0;
                        await_ack_next = 1'b0;
                        if (state_reg == ST_INCALL) begin
                            msg0           = MSG_BYE;
                            count          = 2'd1;
                            media_next     = 1'b0;
                            active_id_next   = '0;
                            incoming_id_next = '0;
                            retry_int_next = 16'd0;
                            retry_cd_next  = 16'd0;
                            state_next     = ST_IDLE;
                            ended          = 1'b1;
                        end
                    end else begin
                        giveup_cd_next = giveup_cd_reg - 20'd1;
                        if (retry_cd_reg <= 16'd1) begin
                            msg0  = MSG_OK_RESEND;
                            count = 2'd1;
                            if (retry_double > {1'b0, cfg.retry_ceiling_ms}) begin
                                retry_int_next = cfg.retry_ceiling_ms;
                                retry_cd_next  = cfg.retry_ceiling_ms;
                            end else begin
                                retry_int_next = retry_double[15:0];
                                retry_cd_next  = retry_double[15:0];
                            end
                        end else begin
                            retry_cd_next = retry_cd_reg - 16'd1;
                        end
                    end
                end
                // Registration refresh timer; a due refresh waits for idle.
                if (reg_armed_reg && !reg_pending_reg) begin
                    reg_cd_next = reg_cd_dec;
                    if (reg_cd_dec == 32'd0 && state_next == ST_IDLE) begin
                        reg_pending_next = 1'b1;
                        if (count == 2'd0) begin
                            msg0 = MSG_REGISTER;
                        end else begin
                            msg1 = MSG_REGISTER;
                        end
                        count = count + 2'd1;
                    end
                end
            end
            CMD_PLACE: begin
                if (state_reg == ST_IDLE) begin
                    media_next       = 1'b0;
                    await_ack_next   = 1'b0;
                    incoming_id_next = '0;
                    retry_int_next   = 16'd0;
                    retry_cd_next    = 16'd0;
                    giveup_cd_next   = 20'd0;
                    active_id_next   = cid;
                    state_next       = ST_CALLING;
                    msg0             = MSG_INVITE;
                    count            = 2'd1;
                    ok               = 1'b1;
                end
            end
            CMD_CALL_RESP: begin
                if (state_reg == ST_CALLING) begin
                    if (status_code == STATUS_OK) begin
                        msg0       = MSG_ACK;
                        count      = 2'd1;
                        media_next = 1'b1;
                        state_next = ST_INCALL;
                        ok         = media_valid;
                    end else if (status_code >= STATUS_FAIL_MIN) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            CMD_NO_ANSWER: begin
                if (state_reg == ST_CALLING) begin
                    state_next = ST_IDLE;
                end
            end
            CMD_INVITE: begin
                count = 2'd1;
                if (state_reg != ST_IDLE) begin
                    msg0 = MSG_BUSY_GEN;
                end else begin
                    media_next       = 1'b0;
                    await_ack_next   = 1'b0;
                    active_id_next   = '0;
                    retry_int_next   = 16'd0;
                    retry_cd_next    = 16'd0;
                    giveup_cd_next   = 20'd0;
                    incoming_id_next = cid;
                    state_next       = ST_RINGING;
                    msg0             = MSG_RINGING;
                end
            end
            CMD_BYE: begin
                msg0  = MSG_OK_GEN;
                count = 2'd1;
                if (state_reg == ST_INCALL) begin
                    media_next       = 1'b0;
                    await_ack_next   = 1'b0;
                    active_id_next   = '0;
                    incoming_id_next = '0;
                    retry_int_next   = 16'd0;
                    retry_cd_next    = 16'd0;
                    giveup_cd_next   = 20'd0;
                    state_next       = ST_IDLE;
                    ended            = 1'b1;
                end
            end
            CMD_CANCEL: begin
                msg0  = MSG_OK_GEN;
                count = 2'd1;
                if (state_reg == ST_RINGING && cid == incoming_id_reg) begin
                    msg1             = MSG_TERMINATED;
                    count            = 2'd2;
                    media_next       = 1'b0;
                    await_ack_next   = 1'b0;
                    active_id_next   = '0;
                    incoming_id_next = '0;
                    retry_int_next   = 16'd0;
                    retry_cd_next    = 16'd0;
                    giveup_cd_next   = 20'd0;
                    state_next       = ST_IDLE;
                    ended            = 1'b1;
                end
            end
            CMD_ACK: begin
                if (await_ack_reg && cid == active_id_reg) begin
                    await_ack_next = 1'b0;
                end
            end
            CMD_OPTIONS: begin
                msg0  = MSG_OK_GEN;
                count = 2'd1;
            end
            CMD_ANSWER: begin
                if (state_reg == ST_RINGING) begin
                    msg0           = MSG_OK_SDP;
                    count          = 2'd1;
                    await_ack_next = 1'b1;
                    retry_int_next = cfg.first_retry_ms;
                    retry_cd_next  = cfg.first_retry_ms;
                    giveup_cd_next = cfg.ack_timeout_ms;
                    active_id_next = incoming_id_reg;
                    media_next     = 1'b1;
                    state_next     = ST_INCALL;
                    ok             = 1'b1;
                end
            end
            CMD_REJECT, CMD_HANGUP: begin
                // Reject works while ringing only; hangup in any active state.
                if (state_reg == ST_RINGING ||
                    (cmd_t'(command) == CMD_HANGUP && state_reg != ST_IDLE)) begin
                    if (state_reg == ST_INCALL) begin
                        msg0 = MSG_BYE;
                    end else if (state_reg == ST_CALLING) begin
                        msg0 = MSG_CANCEL;
                    end else begin
                        msg0 = MSG_BUSY;
                    end
                    count            = 2'd1;
                    media_next       = 1'b0;
                    await_ack_next   = 1'b0;
                    active_id_next   = '0;
                    incoming_id_next = '0;
                    retry_int_next   = 16'd0;
                    retry_cd_next    = 16'd0;
                    giveup_cd_next   = 20'd0;
                    state_next       = ST_IDLE;
                end
            end
            CMD_REG_RESULT: begin
                if (status_code == STATUS_OK) begin
                    reg_armed_next   = 1'b1;
                    reg_pending_next = 1'b0;
                    reg_cd_next      = cfg.refresh_ms;
                end else if (status_code == STATUS_NONE || status_code >= STATUS_FAIL_MIN) begin
                    if (reg_pending_reg) begin
                        reg_pending_next = 1'b0;
                        reg_cd_next      = cfg.reg_retry_ms;
                    end
                end
            end
            default: ;
        endcase

        // Every command except the tick reports at least once.
        if (cmd_t'(command) != CMD_TICK && command <= CMD_REG_RESULT && count == 2'd0) begin
            msg0  = MSG_NONE;
            count = 2'd1;
        end
    end

    // Result items as seen after the whole event.
    always_comb begin
        push.count              = in_fire ? count : 2'd0;
        push.res0.message       = msg0;
        push.res0.call_state    = state_code(state_next);
        push.res0.media_on      = media_next;
        push.res0.ended_by_peer = ended && (count == 2'd1);
        push.res0.request_ok    = ok;
        push.res0.last          = (count == 2'd1);
        push.res1.message       = msg1;
        push.res1.call_state    = state_code(state_next);
        push.res1.media_on      = media_next;
        push.res1.ended_by_peer = ended;
        push.res1.request_ok    = ok;
        push.res1.last          = 1'b1;
    end

    // State update on each accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            active_id_reg   <= '0;
            incoming_id_reg <= '0;
            await_ack_reg   <= 1'b0;
            retry_int_reg   <= 16'd0;
            retry_cd_reg    <= 16'd0;
            giveup_cd_reg   <= 20'd0;
            media_reg       <= 1'b0;
            reg_armed_reg   <= 1'b0;
            reg_pending_reg <= 1'b0;
            reg_cd_reg      <= 32'd0;
        end else if (in_fire) begin
            state_reg       <= state_next;
            active_id_reg   <= active_id_next;
            incoming_id_reg <= incoming_id_next;
            await_ack_reg   <= await_ack_next;
            retry_int_reg   <= retry_int_next;
            retry_cd_reg    <= retry_cd_next;
            giveup_cd_reg   <= giveup_cd_next;
            media_reg       <= media_next;
            reg_armed_reg   <= reg_armed_next;
            reg_pending_reg <= reg_pending_next;
            reg_cd_reg      <= reg_cd_next;
        end
    end

endmodule

@@ rtl/core/sipcdc_result_fifo.sv @@
// Result queue of the SIP call dialog controller: takes up to two results a cycle,
// hands one per transfer to the output channel. Depends on sipcdc_pkg.
module sipcdc_result_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sipcdc_pkg::push_t    push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sipcdc_pkg::result_t  out_res
);
    import sipcdc_pkg::*;

    localparam int PTR_W = $clog2(RES_DEPTH);

    result_t            entry_reg [RES_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_second;
    logic [PTR_W:0]     count_reg, count_next;
    logic               pop;

    assign out_valid     = (count_reg != '0);
    assign out_res       = entry_reg[rd_ptr_reg];
    assign pop           = out_valid & out_ready;
    assign room          = (count_reg <= (PTR_W + 1)'(RES_DEPTH - 2));
    assign wr_ptr_second = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next   = wr_ptr_reg + PTR_W'(push.count);
    assign count_next    = count_reg + (PTR_W + 1)'(push.count) - (PTR_W + 1)'(pop);

    // Payload storage.
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            entry_reg[wr_ptr_second] <= push.res1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/sip_call_dialog_controller_top.sv @@
// Top level of the SIP call dialog controller: stream channels and APB-style port.
// Instantiates sipcdc_cfg_regs, sipcdc_core and sipcdc_result_fifo; uses sipcdc_pkg.
//
// Usage:
// - Events enter on the s_ channel: s_tuser carries the command, s_tdata the call id,
//   status code and media flag. One tick event stands for one millisecond.
// - Each event yields zero to two result items on the m_ channel, in order; m_tlast
//   marks the final result of an event. A tick yields only the messages it sends.
// - The configuration registers are written and read through the APB-style port,
//   which is always ready; write them only while no event is in flight.
// - The first result of an event is offered from the registered result queue.
// - Throughput: one event per cycle is accepted while the result queue has room for
//   two items. The output port moves one result per cycle while m_tready is high, so
//   an event with two results takes two output transfers.
// - The four-entry result queue decouples the sides: events are still taken while
//   results wait. When the receiver stalls, the queue fills and s_tready drops.
// - Reset (aresetn low, synchronous) returns the call to idle, clears ids and timers,
//   empties the queue and loads the register reset values.
module sip_call_dialog_controller_top #(
    parameter int ID_BITS = sipcdc_pkg::ID_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] call_id, [41:32] status_code, [42] media_valid
    input  logic [3:0]  s_tuser,   // [3:0] command
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] message, [5:4] call_state, [6] media_on,
                                   // [7] ended_by_peer, [8] request_ok
    output logic        m_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sipcdc_pkg::*;

    cfg_t    cfg;
    push_t   push;
    result_t out_res;
    logic    room;
    logic    in_fire;

    assign s_tready = room;
    assign in_fire  = s_tvalid & room;

    sipcdc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sipcdc_core #(
        .ID_BITS (ID_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_fire     (in_fire),
        .command     (s_tuser),
        .call_id     (s_tdata[31:0]),
        .status_code (s_tdata[41:32]),
        .media_valid (s_tdata[42]),
        .cfg         (cfg),
        .push        (push)
    );

    sipcdc_result_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Result packing onto the output channel.
    assign m_tdata = {7'd0, out_res.request_ok, out_res.ended_by_peer, out_res.media_on,
                      out_res.call_state, out_res.message};
    assign m_tlast = out_res.last;

endmodule

@@ rtl/core/sipcdc_checker.sv @@
// Port-level checks of the SIP call dialog controller result channel.
// Bound to sip_call_dialog_controller_top; takes its codes from sipcdc_pkg.
module sipcdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);
    import sipcdc_pkg::*;

    // The result channel is empty after a reset cycle.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled result holds its contents.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // An ended call is flagged on the final result only.
    a_ended_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> m_tlast)
        else $error("ended_by_peer on a result that is not the last");

    // A call ended by the peer is back in idle.
    a_ended_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> m_tdata[5:4] == state_code(ST_IDLE))
        else $error("ended_by_peer while the call is not idle");

    // The empty message never shares an event with another result.
    a_none_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] == MSG_NONE |-> m_tlast)
        else $error("empty message followed by further results");

endmodule

bind sip_call_dialog_controller_top sipcdc_checker u_sipcdc_checker (.*);

@@ test/dialog_check_pkg.sv @@
// Expected-result tracking for the SIP call dialog controller testbench.
// Holds a cycle-free model of the call and timer state; depends on sipcdc_pkg.
package dialog_check_pkg;
    import sipcdc_pkg::*;

    // Binary call state as it appears on the result channel.
    typedef enum logic [1:0] {
        CALL_IDLE    = 2'd0,
        CALL_CALLING = 2'd1,
        CALL_RINGING = 2'd2,
        CALL_ACTIVE  = 2'd3
    } call_code_t;

    // Command codes beyond the defined set, which the block ignores.
    localparam logic [3:0] CMD_UNUSED_LO = 4'd13;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    // SIP status codes used by the stimulus.
    localparam logic [9:0] STATUS_TRYING   = 10'd100;
    localparam logic [9:0] STATUS_RINGING  = 10'd180;
    localparam logic [9:0] STATUS_PROGRESS = 10'd183;
    localparam logic [9:0] STATUS_NOTFOUND = 10'd404;
    localparam logic [9:0] STATUS_BUSY     = 10'd486;
    localparam logic [9:0] STATUS_DECLINE  = 10'd603;
    localparam logic [9:0] STATUS_MAX      = 10'd699;

    class dialog_tracker;
        // Copy of the configuration registers.
        logic [15:0] first_retry;
        logic [15:0] retry_ceiling;
        logic [19:0] ack_timeout;
        logic [31:0] refresh_delay;
        logic [31:0] reg_retry_delay;

        // Copy of the call and timer state.
        call_code_t  dlg;
        logic [31:0] active_id;
        logic [31:0] incoming_id;
        bit          await_ack;
        bit          media_armed;
        bit          reg_armed;
        bit          reg_pending;
        logic [15:0] retry_interval;
        logic [15:0] retry_countdown;
        logic [19:0] giveup_countdown;
        logic [31:0] reg_countdown;

        // Results still owed by the block, oldest first.
        result_t     owed_results[$];
        msg_t        sent[$];
        bit          peer_ended;

        int          errors;
        int          events_noted;
        int          results_checked;
        int          giveups;
        int          msg_count[16];

        function new();
            errors = 0;
            events_noted = 0;
            results_checked = 0;
            giveups = 0;
            foreach (msg_count[i]) msg_count[i] = 0;
            first_retry = FIRST_RETRY_RST;
            retry_ceiling = RETRY_CEILING_RST;
            ack_timeout = ACK_TIMEOUT_RST;
            refresh_delay = REFRESH_RST;
            reg_retry_delay = REG_RETRY_RST;
            dlg = CALL_IDLE;
            clear_dialog();
            reg_armed = 0;
            reg_pending = 0;
            reg_countdown = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_FIRST_RETRY:   first_retry = val[15:0];
                REG_RETRY_CEILING: retry_ceiling = val[15:0];
                REG_ACK_TIMEOUT:   ack_timeout = val[19:0];
                REG_REFRESH:       refresh_delay = val;
                REG_REG_RETRY:     reg_retry_delay = val;
                default: ;
            endcase
        endfunction

        function void clear_dialog();
            media_armed = 0;
            await_ack = 0;
            active_id = '0;
            incoming_id = '0;
            retry_interval = '0;
            retry_countdown = '0;
            giveup_countdown = '0;
        endfunction

        // At most two messages leave per event.
        function void emit(msg_t m);
            if (sent.size() < 2) sent.push_back(m);
        endfunction

        // One millisecond: ACK give-up, 200 OK resend and registration refresh.
        function void elapse_ms();
            logic [16:0] doubled;
            if (await_ack) begin
                if (giveup_countdown <= 1) begin
                    giveup_countdown = '0;
                    await_ack = 0;
                    if (dlg == CALL_ACTIVE) begin
                        emit(MSG_BYE);
                        clear_dialog();
                        dlg = CALL_IDLE;
                        peer_ended = 1;
                        giveups++;
                    end
                end else begin
                    giveup_countdown = giveup_countdown - 20'd1;
                    if (retry_countdown <= 1) begin
                        doubled = {retry_interval, 1'b0};
                        emit(MSG_OK_RESEND);
                        retry_interval = (doubled > {1'b0, retry_ceiling}) ?
                                         retry_ceiling : doubled[15:0];
                        retry_countdown = retry_interval;
                    end else begin
                        retry_countdown = retry_countdown - 16'd1;
                    end
                end
            end
            // The refresh waits at zero until the call has ended.
            if (reg_armed && !reg_pending) begin
                if (reg_countdown > 0) reg_countdown = reg_countdown - 32'd1;
                if (reg_countdown == 0 && dlg == CALL_IDLE) begin
                    emit(MSG_REGISTER);
                    reg_pending = 1;
                end
            end
        endfunction

        // Work out the results of one accepted input transfer.
        function void note_event(logic [3:0] cmd, logic [31:0] cid, logic [9:0] code,
                                 bit mvalid);
            bit      ok;
            result_t r;
            int      k;
            ok = 0;
            peer_ended = 0;
            sent.delete();
            events_noted++;
            if (cmd > CMD_REG_RESULT) return;

            case (cmd)
                CMD_TICK: elapse_ms();
                CMD_PLACE: begin
                    if (dlg == CALL_IDLE) begin
                        clear_dialog();
                        active_id = cid;
                        dlg = CALL_CALLING;
                        emit(MSG_INVITE);
                        ok = 1;
                    end
                end
                CMD_CALL_RESP: begin
                    if (dlg == CALL_CALLING) begin
                        if (code == STATUS_OK) begin
                            emit(MSG_ACK);
                            media_armed = 1;
                            dlg = CALL_ACTIVE;
                            ok = mvalid;
                        end else if (code >= STATUS_FAIL_MIN) begin
                            dlg = CALL_IDLE;
                        end
                    end
                end
                CMD_NO_ANSWER: begin
                    if (dlg == CALL_CALLING) dlg = CALL_IDLE;
                end
                CMD_INVITE: begin
                    if (dlg != CALL_IDLE) begin
                        emit(MSG_BUSY_GEN);
                    end else begin
                        clear_dialog();
                        incoming_id = cid;
                        dlg = CALL_RINGING;
                        emit(MSG_RINGING);
                    end
                end
                CMD_BYE: begin
                    emit(MSG_OK_GEN);
                    if (dlg == CALL_ACTIVE) begin
                        clear_dialog();
                        dlg = CALL_IDLE;
                        peer_ended = 1;
                    end
                end
                CMD_CANCEL: begin
                    emit(MSG_OK_GEN);
                    if (dlg == CALL_RINGING && cid == incoming_id) begin
                        emit(MSG_TERMINATED);
                        clear_dialog();
                        dlg = CALL_IDLE;
                        peer_ended = 1;
                    end
                end
                CMD_ACK: begin
                    if (await_ack && cid == active_id) await_ack = 0;
                end
                CMD_OPTIONS: emit(MSG_OK_GEN);
                CMD_ANSWER: begin
                    if (dlg == CALL_RINGING) begin
                        emit(MSG_OK_SDP);
                        await_ack = 1;
                        retry_interval = first_retry;
                        retry_countdown = first_retry;
                        giveup_countdown = ack_timeout;
                        active_id = incoming_id;
                        media_armed = 1;
                        dlg = CALL_ACTIVE;
                        ok = 1;
                    end
                end
                CMD_REJECT: begin
                    if (dlg == CALL_RINGING) begin
                        emit(MSG_BUSY);
                        clear_dialog();
                        dlg = CALL_IDLE;
                    end
                end
                CMD_HANGUP: begin
                    if (dlg != CALL_IDLE) begin
                        if (dlg == CALL_ACTIVE) emit(MSG_BYE);
                        else if (dlg == CALL_CALLING) emit(MSG_CANCEL);
                        else emit(MSG_BUSY);
                        clear_dialog();
                        dlg = CALL_IDLE;
                    end
                end
                default: begin
                    // Registration result.
                    if (code == STATUS_OK) begin
                        reg_armed = 1;
                        reg_pending = 0;
                        reg_countdown = refresh_delay;
                    end else if (code == STATUS_NONE || code >= STATUS_FAIL_MIN) begin
                        if (reg_pending) begin
                            reg_pending = 0;
                            reg_countdown = reg_retry_delay;
                        end
                    end
                end
            endcase

            // Every command but a tick answers with at least one result.
            if (cmd != CMD_TICK && sent.size() == 0) emit(MSG_NONE);

            for (k = 0; k < sent.size(); k++) begin
                r.message = sent[k];
                r.call_state = dlg;
                r.media_on = media_armed;
                r.ended_by_peer = (k == sent.size() - 1) && peer_ended;
                r.request_ok = ok;
                r.last = (k == sent.size() - 1);
                owed_results.push_back(r);
                msg_count[sent[k]]++;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // Compare one result transfer with the oldest owed result.
        function void check_result(logic [15:0] data, logic tlast);
            result_t want;
            results_checked++;
            if (owed_results.size() == 0) begin
                $error("result transfer with none outstanding: message %0d", data[3:0]);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("message", want.message, data[3:0]);
            compare_field("call_state", want.call_state, data[5:4]);
            compare_field("media_on", want.media_on, data[6]);
            compare_field("ended_by_peer", want.ended_by_peer, data[7]);
            compare_field("request_ok", want.request_ok, data[8]);
            compare_field("last", want.last, tlast);
        endfunction
    endclass

endpackage

@@ test/tb.sv @@
// Testbench top for sip_call_dialog_controller_top: stream stimulus, APB register setup
// and result checking. Depends on sipcdc_pkg and dialog_check_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sipcdc_pkg::*;
    import dialog_check_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [31:0] call_id, [41:32] status_code, [42] media_valid
    logic [3:0]  s_tuser;   // [3:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [3:0] message, [5:4] call_state, [6] media_on,
                            // [7] ended_by_peer, [8] request_ok
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dialog_tracker tracker = new();
    bit            no_idle = 0;
    int            settings_used = 0;
    int            quiet_cycles = 0;

    sip_call_dialog_controller_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Idle gap length: mostly none or short, now and then long.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: ready toggles with random stalls.
    initial begin
        int hold;
        m_tready = 1'b0;
        forever begin
            hold = idle_gap();
            if (hold > 0) begin
                m_tready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_tready = 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    end

    // Each result transfer is checked against the oldest owed result.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tlast);
    end

    // Watchdog on cycles in which neither channel makes a transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One input transfer; called at a falling edge, returns at the falling edge after it.
    task automatic send_event(logic [3:0] cmd, logic [31:0] cid, logic [9:0] code, bit mv);
        s_tuser = cmd;
        s_tdata = {5'd0, mv, code, cid};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.note_event(cmd, cid, code, mv);
        @(negedge aclk);
    endtask

    task automatic push_event(logic [3:0] cmd, logic [31:0] cid, logic [9:0] code, bit mv);
        int gap;
        send_event(cmd, cid, code, mv);
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Wait until every owed result has arrived and the block has gone quiet.
    task automatic settle();
        s_tvalid = 1'b0;
        while (tracker.owed_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_reg(idx, val);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic program_regs(logic [15:0] fr, logic [15:0] ceil, logic [19:0] ack,
                                logic [31:0] refresh, logic [31:0] retry);
        apb_write(REG_FIRST_RETRY, {16'd0, fr});
        apb_write(REG_RETRY_CEILING, {16'd0, ceil});
        apb_write(REG_ACK_TIMEOUT, {12'd0, ack});
        apb_write(REG_REFRESH, refresh);
        apb_write(REG_REG_RETRY, retry);
        settings_used++;
    endtask

    function automatic logic [9:0] resp_code();
        case ($urandom_range(0, 7))
            0:       return STATUS_TRYING;
            1:       return STATUS_RINGING;
            2:       return STATUS_PROGRESS;
            3, 4:    return STATUS_OK;
            5:       return STATUS_BUSY;
            6:       return STATUS_DECLINE;
            default: return 10'($urandom_range(0, STATUS_MAX));
        endcase
    endfunction

    function automatic logic [9:0] reg_code();
        case ($urandom_range(0, 5))
            0, 1:    return STATUS_OK;
            2:       return STATUS_NONE;
            3:       return STATUS_NOTFOUND;
            4:       return STATUS_RINGING;
            default: return 10'($urandom_range(0, STATUS_MAX));
        endcase
    endfunction

    // Random event shaped by the current call state, with some plain noise.
    task automatic random_event();
        logic [3:0]  cmd;
        logic [31:0] cid;
        logic [9:0]  code;
        bit          mv;
        int          r;
        cid = $urandom;
        code = 10'($urandom_range(0, STATUS_MAX));
        mv = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        cmd = CMD_TICK;
        if (r < 6) begin
            cmd = 4'($urandom_range(0, 15));
        end else begin
            r = $urandom_range(0, 99);
            case (tracker.dlg)
                CALL_IDLE: begin
                    if (r < 40) cmd = CMD_TICK;
                    else if (r < 55) cmd = CMD_INVITE;
                    else if (r < 70) cmd = CMD_PLACE;
                    else if (r < 82) begin
                        cmd = CMD_REG_RESULT;
                        code = reg_code();
                    end else cmd = 4'($urandom_range(CMD_CALL_RESP, CMD_HANGUP));
                end
                CALL_CALLING: begin
                    if (r < 30) cmd = CMD_TICK;
                    else if (r < 65) begin
                        cmd = CMD_CALL_RESP;
                        code = resp_code();
                    end else if (r < 72) cmd = CMD_NO_ANSWER;
                    else if (r < 78) cmd = CMD_HANGUP;
                    else if (r < 84) cmd = CMD_INVITE;
                    else if (r < 90) begin
                        cmd = CMD_REG_RESULT;
                        code = reg_code();
                    end else cmd = 4'($urandom_range(CMD_BYE, CMD_OPTIONS));
                end
                CALL_RINGING: begin
                    if (r < 25) cmd = CMD_TICK;
                    else if (r < 50) cmd = CMD_ANSWER;
                    else if (r < 60) cmd = CMD_REJECT;
                    else if (r < 72) begin
                        cmd = CMD_CANCEL;
                        if ($urandom_range(0, 3) != 0) cid = tracker.incoming_id;
                    end else if (r < 78) cmd = CMD_HANGUP;
                    else if (r < 84) cmd = CMD_INVITE;
                    else if (r < 90) cmd = CMD_BYE;
                    else if (r < 95) cmd = CMD_OPTIONS;
                    else begin
                        cmd = CMD_REG_RESULT;
                        code = reg_code();
                    end
                end
                default: begin
                    if (r < 55) cmd = CMD_TICK;
                    else if (r < 70) begin
                        cmd = CMD_ACK;
                        if ($urandom_range(0, 4) != 0) cid = tracker.active_id;
                    end else if (r < 78) cmd = CMD_BYE;
                    else if (r < 84) cmd = CMD_HANGUP;
                    else if (r < 88) cmd = CMD_OPTIONS;
                    else if (r < 92) cmd = CMD_INVITE;
                    else if (r < 96) begin
                        cmd = CMD_REG_RESULT;
                        code = reg_code();
                    end else cmd = CMD_CANCEL;
                end
            endcase
        end
        push_event(cmd, cid, code, mv);
    endtask

    task automatic run_random(int count);
        repeat (count) random_event();
    endtask

    // Directed opening under the reset register values.
    task automatic directed();
        push_event(CMD_TICK, '0, STATUS_NONE, 1'b0);
        push_event(CMD_UNUSED_LO, '0, STATUS_NONE, 1'b0);
        push_event(CMD_UNUSED_HI, '1, STATUS_MAX, 1'b1);
        push_event(CMD_OPTIONS, '0, STATUS_NONE, 1'b0);
        push_event(CMD_ANSWER, '0, STATUS_NONE, 1'b0);
        push_event(CMD_INVITE, 32'hFFFF_FFFF, STATUS_MAX, 1'b1);
        push_event(CMD_INVITE, '0, STATUS_NONE, 1'b0);
        push_event(CMD_CANCEL, '0, STATUS_NONE, 1'b0);
        push_event(CMD_ANSWER, '0, STATUS_NONE, 1'b0);
        push_event(CMD_TICK, '0, STATUS_NONE, 1'b0);
        push_event(CMD_ACK, '0, STATUS_NONE, 1'b0);
        push_event(CMD_ACK, 32'hFFFF_FFFF, STATUS_NONE, 1'b0);
        push_event(CMD_BYE, '0, STATUS_NONE, 1'b0);
        push_event(CMD_PLACE, 32'h1234_5678, STATUS_NONE, 1'b0);
        push_event(CMD_CALL_RESP, '0, STATUS_RINGING, 1'b0);
        push_event(CMD_CALL_RESP, '0, STATUS_OK, 1'b1);
        push_event(CMD_HANGUP, '0, STATUS_NONE, 1'b0);
        push_event(CMD_PLACE, 32'h8765_4321, STATUS_NONE, 1'b0);
        push_event(CMD_CALL_RESP, '0, STATUS_BUSY, 1'b1);
        push_event(CMD_PLACE, 32'h0000_0001, STATUS_NONE, 1'b0);
        push_event(CMD_NO_ANSWER, '0, STATUS_NONE, 1'b0);
        push_event(CMD_PLACE, 32'h0000_0002, STATUS_NONE, 1'b0);
        push_event(CMD_HANGUP, '0, STATUS_NONE, 1'b0);
        push_event(CMD_INVITE, 32'h5555_AAAA, STATUS_NONE, 1'b0);
        push_event(CMD_REJECT, '0, STATUS_NONE, 1'b0);
        push_event(CMD_INVITE, 32'hAAAA_5555, STATUS_NONE, 1'b0);
        push_event(CMD_CANCEL, 32'hAAAA_5555, STATUS_NONE, 1'b0);
        push_event(CMD_REG_RESULT, '0, STATUS_OK, 1'b0);
        push_event(CMD_REG_RESULT, '0, STATUS_MAX, 1'b0);
    endtask

    // Reset, directed opening, then random phases under several register settings.
    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed();

        // Short timers so that resends, give-ups and refreshes happen often.
        settle();
        program_regs(16'($urandom_range(1, 4)), 16'($urandom_range(1, 12)),
                     20'($urandom_range(4, 40)), 32'($urandom_range(2, 30)),
                     32'($urandom_range(1, 20)));
        run_random(475);

        // Every timer set to one, its smallest nonzero value.
        settle();
        program_regs(16'd1, 16'd1, 20'd1, 32'd1, 32'd1);
        run_random(475);

        // Every timer at its maximum, with no idling on either side.
        settle();
        no_idle = 1;
        program_regs(16'hFFFF, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(300);
        no_idle = 0;

        // Ceiling below the first interval, so that doubling is clipped at once.
        settle();
        program_regs(16'($urandom_range(5, 9)), 16'($urandom_range(1, 4)),
                     20'($urandom_range(10, 60)), 32'($urandom_range(1, 40)),
                     32'($urandom_range(1, 10)));
        run_random(650);

        // Drain the result channel, then allow a few quiet cycles.
        settle();
        repeat (10) @(posedge aclk);

        $display("Run covered %0d events and %0d results under %0d register settings.",
                 tracker.events_noted, tracker.results_checked, settings_used + 1);
        $display("Seen: %0d 200 resends, %0d ACK give-ups, %0d REGISTER sends, %0d 487s.",
                 tracker.msg_count[MSG_OK_RESEND], tracker.giveups,
                 tracker.msg_count[MSG_REGISTER], tracker.msg_count[MSG_TERMINATED]);
        if (tracker.errors == 0 && tracker.owed_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
